### design/tdsu_pkg.sv
// Shared types and constants for the terminal delta screen update block.
`default_nettype none
package tdsu_pkg;

  localparam int unsigned MaxScreenDim = 256;
  localparam int unsigned DimW         = $clog2(MaxScreenDim + 1);
  localparam int unsigned PosW         = $clog2(MaxScreenDim);
  localparam int unsigned ColorW       = 5;
  localparam int unsigned CharW        = 8;
  localparam int unsigned CmdW         = 2;
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [ColorW-1:0] NoColor = ColorW'(16);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 1'b1;

  localparam logic [DimW-1:0] WidthReset  = DimW'(80);
  localparam logic [DimW-1:0] HeightReset = DimW'(25);

  typedef enum logic [CmdW-1:0] {
    CMD_MOVE  = 2'd0,
    CMD_COLOR = 2'd1,
    CMD_CHAR  = 2'd2
  } cmd_e;

  // One bit per result an item may cause; the lowest bit is emitted first.
  typedef struct packed {
    logic end_move;
    logic put_char;
    logic set_color;
    logic move;
    logic clr_color;
  } res_mask_t;

  typedef struct packed {
    res_mask_t          mask;
    logic [PosW-1:0]    col;
    logic [PosW-1:0]    row;
    logic [ColorW-1:0]  fore;
    logic [ColorW-1:0]  back;
    logic [CharW-1:0]   chr;
    logic [PosW-1:0]    last_col;
    logic [PosW-1:0]    last_row;
  } pend_t;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxScreenDim)) begin
      r = DimW'(MaxScreenDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/tdsu_diff.sv
// Cell comparison, position counters and run/colour tracking state.
`default_nettype none
module tdsu_diff (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [tdsu_pkg::DimW-1:0]     width_i,
  input  wire logic [tdsu_pkg::DimW-1:0]     height_i,
  input  wire logic [tdsu_pkg::CharW-1:0]    old_char_i,
  input  wire logic [tdsu_pkg::ColorW-1:0]   old_fore_i,
  input  wire logic [tdsu_pkg::ColorW-1:0]   old_back_i,
  input  wire logic [tdsu_pkg::CharW-1:0]    new_char_i,
  input  wire logic [tdsu_pkg::ColorW-1:0]   new_fore_i,
  input  wire logic [tdsu_pkg::ColorW-1:0]   new_back_i,
  output tdsu_pkg::pend_t                    pend_o
);

  logic [tdsu_pkg::PosW-1:0]   col_q, col_d, row_q, row_d;
  logic                        run_q, run_d;
  logic [tdsu_pkg::ColorW-1:0] sfore_q, sfore_d, sback_q, sback_d;

  logic [tdsu_pkg::DimW-1:0]   w, h;
  logic                        row_start, frame_start, row_end, frame_end;
  logic                        changed, run_eff, color_diff;
  logic [tdsu_pkg::ColorW-1:0] sfore_eff, sback_eff;

  always_comb begin
    w           = tdsu_pkg::clamp_dim(width_i);
    h           = tdsu_pkg::clamp_dim(height_i);
    row_start   = (col_q == '0);
    frame_start = row_start && (row_q == '0);
    row_end     = ({1'b0, col_q} + tdsu_pkg::DimW'(1)) >= w;
    frame_end   = row_end && (({1'b0, row_q} + tdsu_pkg::DimW'(1)) >= h);
    changed     = (old_char_i != new_char_i) || (old_fore_i != new_fore_i) ||
                  (old_back_i != new_back_i);
    run_eff     = row_start ? 1'b0 : run_q;
    sfore_eff   = frame_start ? tdsu_pkg::NoColor : sfore_q;
    sback_eff   = frame_start ? tdsu_pkg::NoColor : sback_q;
    color_diff  = (new_fore_i != sfore_eff) || (new_back_i != sback_eff);

    pend_o.mask.clr_color = frame_start;
    pend_o.mask.move      = changed && !run_eff;
    pend_o.mask.set_color = changed && color_diff;
    pend_o.mask.put_char  = changed;
    pend_o.mask.end_move  = frame_end;
    pend_o.col            = col_q;
    pend_o.row            = row_q;
    pend_o.fore           = new_fore_i;
    pend_o.back           = new_back_i;
    pend_o.chr            = new_char_i;
    pend_o.last_col       = tdsu_pkg::PosW'(w - tdsu_pkg::DimW'(1));
    pend_o.last_row       = tdsu_pkg::PosW'(h - tdsu_pkg::DimW'(1));

    run_d   = changed;
    sfore_d = (changed && color_diff) ? new_fore_i : sfore_eff;
    sback_d = (changed && color_diff) ? new_back_i : sback_eff;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + tdsu_pkg::PosW'(1);
    end else begin
      col_d = col_q + tdsu_pkg::PosW'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      run_q   <= 1'b0;
      sfore_q <= tdsu_pkg::NoColor;
      sback_q <= tdsu_pkg::NoColor;
    end else if (accept_i) begin
      col_q   <= col_d;
      row_q   <= row_d;
      run_q   <= run_d;
      sfore_q <= sfore_d;
      sback_q <= sback_d;
    end
  end

endmodule
`default_nettype wire

### design/tdsu_serial.sv
// Result register that holds one cell's pending results and emits them in order.
`default_nettype none
module tdsu_serial (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  output logic                               accept_o,
  input  wire tdsu_pkg::pend_t               pend_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tdsu_pkg::CmdW-1:0]          command_o,
  output logic [tdsu_pkg::PosW-1:0]          cursor_col_o,
  output logic [tdsu_pkg::PosW-1:0]          cursor_row_o,
  output logic [tdsu_pkg::ColorW-1:0]        fore_color_o,
  output logic [tdsu_pkg::ColorW-1:0]        back_color_o,
  output logic [tdsu_pkg::CharW-1:0]         out_char_o,
  output logic                               last_of_run_o
);

  tdsu_pkg::pend_t   pend_q;
  tdsu_pkg::res_mask_t mask_q, mask_d, rest;
  tdsu_pkg::cmd_e    cmd;
  logic              out_take;

  always_comb begin
    rest = mask_q & (mask_q - 5'd1);
    out_valid_o   = (mask_q != '0);
    out_take      = out_valid_o && !out_stall_i;
    last_of_run_o = (rest == '0);
    // A new cell enters when the held one is done or its final result leaves now.
    in_stall_o    = out_valid_o && !(out_take && last_of_run_o);
    accept_o      = in_valid_i && !in_stall_o;

    if (accept_o) begin
      mask_d = pend_i.mask;
    end else if (out_take) begin
      mask_d = rest;
    end else begin
      mask_d = mask_q;
    end

    cursor_col_o = '0;
    cursor_row_o = '0;
    fore_color_o = '0;
    back_color_o = '0;
    out_char_o   = '0;
    priority if (mask_q.clr_color) begin
      cmd          = tdsu_pkg::CMD_COLOR;
      fore_color_o = tdsu_pkg::NoColor;
      back_color_o = tdsu_pkg::NoColor;
    end else if (mask_q.move) begin
      cmd          = tdsu_pkg::CMD_MOVE;
      cursor_col_o = pend_q.col;
      cursor_row_o = pend_q.row;
    end else if (mask_q.set_color) begin
      cmd          = tdsu_pkg::CMD_COLOR;
      fore_color_o = pend_q.fore;
      back_color_o = pend_q.back;
    end else if (mask_q.put_char) begin
      cmd        = tdsu_pkg::CMD_CHAR;
      out_char_o = pend_q.chr;
    end else begin
      cmd          = tdsu_pkg::CMD_MOVE;
      cursor_col_o = pend_q.last_col;
      cursor_row_o = pend_q.last_row;
    end
    command_o = cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      pend_q <= pend_i;
    end
  end

endmodule
`default_nettype wire

### design/terminal_delta_screen_update.sv
// Top level of the terminal delta screen update block.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    old/new char, fore, back
//   out      output     out_valid_o / out_stall_i  command, cursor, colors, char, last
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// A cell is compared in the cycle it is accepted and its results (zero to five)
// sit in the result register, leaving one per cycle while out stall is low. The
// next cell is taken in the cycle its predecessor's final result leaves.
// Out stall holds the current result in place.
// Reset clears the counters, the run flag and the sent colours; no result pending.
`default_nettype none
module terminal_delta_screen_update (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tdsu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tdsu_pkg::DimW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tdsu_pkg::CharW-1:0]    old_char_i,
  input  wire logic [tdsu_pkg::ColorW-1:0]   old_fore_i,
  input  wire logic [tdsu_pkg::ColorW-1:0]   old_back_i,
  input  wire logic [tdsu_pkg::CharW-1:0]    new_char_i,
  input  wire logic [tdsu_pkg::ColorW-1:0]   new_fore_i,
  input  wire logic [tdsu_pkg::ColorW-1:0]   new_back_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tdsu_pkg::CmdW-1:0]          command_o,
  output logic [tdsu_pkg::PosW-1:0]          cursor_col_o,
  output logic [tdsu_pkg::PosW-1:0]          cursor_row_o,
  output logic [tdsu_pkg::ColorW-1:0]        fore_color_o,
  output logic [tdsu_pkg::ColorW-1:0]        back_color_o,
  output logic [tdsu_pkg::CharW-1:0]         out_char_o,
  output logic                               last_of_run_o
);

  logic [tdsu_pkg::DimW-1:0] width_q, height_q;
  logic                      accept;
  tdsu_pkg::pend_t           pend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tdsu_pkg::WidthReset;
      height_q <= tdsu_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tdsu_pkg::CfgScreenWidth:  width_q  <= cfg_data_i;
        tdsu_pkg::CfgScreenHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tdsu_diff u_diff (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .width_i    (width_q),
    .height_i   (height_q),
    .old_char_i (old_char_i),
    .old_fore_i (old_fore_i),
    .old_back_i (old_back_i),
    .new_char_i (new_char_i),
    .new_fore_i (new_fore_i),
    .new_back_i (new_back_i),
    .pend_o     (pend)
  );

  tdsu_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .accept_o      (accept),
    .pend_i        (pend),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .command_o     (command_o),
    .cursor_col_o  (cursor_col_o),
    .cursor_row_o  (cursor_row_o),
    .fore_color_o  (fore_color_o),
    .back_color_o  (back_color_o),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
`default_nettype wire
